// File: rtl/pfh_pkg.sv
// Shared constants, types and helper functions of the probe fingerprint hash.
package pfh_pkg;

  // Mixer and combiner constants.
  localparam logic [63:0] MIX_P  = 64'h5555555555555555;
  localparam logic [63:0] MIX_C  = 64'd17316035218449499591;
  localparam logic [63:0] COMB_G = 64'h517cc1b727220a95;

  // Input opcodes.
  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_BEGIN = 2'd1;
  localparam logic [1:0] OP_BYTE  = 2'd2;
  localparam logic [1:0] OP_END   = 2'd3;

  // Commands passed from the front end to the back end.
  localparam logic [1:0] CMD_SEED_CONST = 2'd0;
  localparam logic [1:0] CMD_SEED_OUI   = 2'd1;
  localparam logic [1:0] CMD_MIX        = 2'd2;
  localparam logic [1:0] CMD_EMIT       = 2'd3;

  // Command queue geometry.
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = QAW + 1;

  typedef struct packed {
    logic [1:0]  op;
    logic [63:0] data;
  } cmd_t;

  // Fold the upper half into the lower half.
  function automatic logic [63:0] xs32(input logic [63:0] v);
    return v ^ {32'd0, v[63:32]};
  endfunction

  // Replicate a chunk of one, two, four or eight bytes to 64 bits.
  function automatic logic [63:0] replicate(input logic [63:0] v, input logic [3:0] nbytes);
    logic [63:0] r;
    case (nbytes)
      4'd1:    r = {8{v[7:0]}};
      4'd2:    r = {4{v[15:0]}};
      4'd4:    r = {2{v[31:0]}};
      default: r = v;
    endcase
    return r;
  endfunction

  // Size of the next chunk given the bytes taken and the tag length.
  function automatic logic [3:0] pick_size(input logic [7:0] pos, input logic [7:0] len);
    logic [8:0] p;
    logic [8:0] l;
    logic [3:0] s;
    p = {1'b0, pos};
    l = {1'b0, len};
    if (p + 9'd8 < l) begin
      s = 4'd8;
    end else if (p + 9'd4 < l) begin
      s = 4'd4;
    end else if (p + 9'd2 < l) begin
      s = 4'd2;
    end else begin
      s = 4'd1;
    end
    return s;
  endfunction

endpackage

// File: rtl/pfh_if.sv
// Channel interfaces of the probe fingerprint hash: input, result and configuration.
interface pfh_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [23:0] oui;
  logic [7:0]  ie_length;
  logic [7:0]  data_byte;

  modport source (output valid, output opcode, output oui, output ie_length,
                  output data_byte, input ready);
  modport sink (input valid, input opcode, input oui, input ie_length,
                input data_byte, output ready);
endinterface

interface pfh_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] hash_value;

  modport source (output valid, output hash_value, input ready);
  modport sink (input valid, input hash_value, output ready);
endinterface

interface pfh_cfg_if;
  logic valid;
  logic ready;
  logic use_oui;

  modport source (output valid, output use_oui, input ready);
  modport sink (input valid, input use_oui, output ready);
endinterface

// File: rtl/pfh_front.sv
// Front end: accepts requests, tracks tag and chunk state and issues commands.
module pfh_front (
  input  logic           clk,
  input  logic           rst_n,
  pfh_in_if.sink         in_ch,
  pfh_cfg_if.sink        cfg_ch,
  input  logic           q_full,
  output logic           q_push,
  output pfh_pkg::cmd_t  q_cmd
);

  logic        use_oui_r, use_oui_nxt;
  logic [63:0] buf_r, buf_nxt;
  logic [3:0]  fill_r, fill_nxt;
  logic [3:0]  size_r, size_nxt;
  logic [7:0]  pos_r, pos_nxt;
  logic [7:0]  total_r, total_nxt;

  logic        accept;
  logic [63:0] buf_new;
  logic [3:0]  fill_new;

  // The configuration register is always writable.
  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = !q_full;
  assign accept       = in_ch.valid && in_ch.ready;

  // Classify the request and update the tag state.
  always_comb begin
    use_oui_nxt = use_oui_r;
    buf_nxt     = buf_r;
    fill_nxt    = fill_r;
    size_nxt    = size_r;
    pos_nxt     = pos_r;
    total_nxt   = total_r;
    q_push      = 1'b0;
    q_cmd.op    = pfh_pkg::CMD_EMIT;
    q_cmd.data  = '0;
    buf_new     = buf_r;
    fill_new    = fill_r + 4'd1;

    if (cfg_ch.valid) begin
      use_oui_nxt = cfg_ch.use_oui;
    end

    // Bytes above the fill level are zero, so the new byte drops into its lane.
    buf_new[{fill_r[2:0], 3'b000} +: 8] = in_ch.data_byte;

    if (accept) begin
      case (in_ch.opcode)
        pfh_pkg::OP_START: begin
          buf_nxt    = '0;
          fill_nxt   = '0;
          size_nxt   = '0;
          pos_nxt    = '0;
          total_nxt  = '0;
          q_push     = 1'b1;
          q_cmd.op   = use_oui_r ? pfh_pkg::CMD_SEED_OUI : pfh_pkg::CMD_SEED_CONST;
          q_cmd.data = {40'd0, in_ch.oui};
        end
        pfh_pkg::OP_BEGIN: begin
          buf_nxt   = '0;
          fill_nxt  = '0;
          pos_nxt   = '0;
          total_nxt = in_ch.ie_length;
          size_nxt  = pfh_pkg::pick_size(8'd0, in_ch.ie_length);
        end
        pfh_pkg::OP_BYTE: begin
          // A byte with no open tag is dropped.
          if (pos_r < total_r) begin
            pos_nxt = pos_r + 8'd1;
            if (fill_new >= size_r) begin
              q_push     = 1'b1;
              q_cmd.op   = pfh_pkg::CMD_MIX;
              q_cmd.data = pfh_pkg::replicate(buf_new, size_r);
              buf_nxt    = '0;
              fill_nxt   = '0;
              size_nxt   = pfh_pkg::pick_size(pos_r + 8'd1, total_r);
            end else begin
              buf_nxt  = buf_new;
              fill_nxt = fill_new;
            end
          end
        end
        pfh_pkg::OP_END: begin
          buf_nxt   = '0;
          fill_nxt  = '0;
          size_nxt  = '0;
          pos_nxt   = '0;
          total_nxt = '0;
          q_push    = 1'b1;
          q_cmd.op  = pfh_pkg::CMD_EMIT;
        end
        default: begin
          q_push = 1'b0;
        end
      endcase
    end
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      use_oui_r <= 1'b0;
      buf_r     <= '0;
      fill_r    <= '0;
      size_r    <= '0;
      pos_r     <= '0;
      total_r   <= '0;
    end else begin
      use_oui_r <= use_oui_nxt;
      buf_r     <= buf_nxt;
      fill_r    <= fill_nxt;
      size_r    <= size_nxt;
      pos_r     <= pos_nxt;
      total_r   <= total_nxt;
    end
  end

endmodule

// File: rtl/pfh_queue.sv
// Short command queue between the front end and the back end.
module pfh_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  pfh_pkg::cmd_t  push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           pop_valid,
  output pfh_pkg::cmd_t  pop_cmd
);

  pfh_pkg::cmd_t                entry_r [pfh_pkg::QDEPTH];
  logic [pfh_pkg::QAW-1:0]      wr_ptr_r, wr_ptr_nxt;
  logic [pfh_pkg::QAW-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [pfh_pkg::QCW-1:0]      count_r, count_nxt;
  logic                         do_push;
  logic                         do_pop;

  assign full      = (count_r == pfh_pkg::QCW'(pfh_pkg::QDEPTH));
  assign pop_valid = (count_r != '0);
  assign pop_cmd   = entry_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && pop_valid;

  // Pointer and occupancy update.
  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + pfh_pkg::QAW'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + pfh_pkg::QAW'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + pfh_pkg::QCW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - pfh_pkg::QCW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// File: rtl/pfh_back.sv
// Back end: runs the mixer on a shared 32x32 multiplier, combines and emits the hash.
module pfh_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_valid,
  input  pfh_pkg::cmd_t  q_cmd,
  output logic           q_pop,
  pfh_out_if.source      out_ch
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_ADD1 = 3'd2;
  localparam logic [2:0] S_ADD2 = 3'd3;
  localparam logic [2:0] S_ADD3 = 3'd4;

  logic [2:0]  state_r, state_nxt;
  logic [1:0]  step_r, step_nxt;
  logic        pass_r, pass_nxt;
  logic        phase_r, phase_nxt;
  logic [1:0]  op_r, op_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [63:0] h_r, h_nxt;

  logic [63:0] x_r, x_nxt;
  logic [63:0] prod_r, prod_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic [63:0] t_r, t_nxt;
  logic [7:0]  oui_hi_r, oui_hi_nxt;
  logic [63:0] hash_r, hash_nxt;

  logic [63:0] mul_b;
  logic [31:0] mul_x;
  logic [31:0] mul_y;
  logic [63:0] mul_p;
  logic [63:0] mul_res;
  logic        out_free;

  assign out_ch.valid      = out_valid_r;
  assign out_ch.hash_value = hash_r;
  assign out_free          = !out_valid_r || out_ch.ready;

  // An emit request waits in the queue until the output register is free.
  assign q_pop = (state_r == S_IDLE) && q_valid &&
                 ((q_cmd.op != pfh_pkg::CMD_EMIT) || out_free);

  // Partial products of the low 64 bits of x times the pass constant.
  always_comb begin
    mul_b = pass_r ? pfh_pkg::MIX_C : pfh_pkg::MIX_P;
    case (step_r)
      2'd0: begin
        mul_x = x_r[31:0];
        mul_y = mul_b[31:0];
      end
      2'd1: begin
        mul_x = x_r[31:0];
        mul_y = mul_b[63:32];
      end
      default: begin
        mul_x = x_r[63:32];
        mul_y = mul_b[31:0];
      end
    endcase
    mul_p   = 64'(mul_x) * 64'(mul_y);
    mul_res = acc_r + {prod_r[31:0], 32'd0};
  end

  // Sequencer.
  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    pass_nxt      = pass_r;
    phase_nxt     = phase_r;
    op_nxt        = op_r;
    h_nxt         = h_r;
    x_nxt         = x_r;
    prod_nxt      = prod_r;
    acc_nxt       = acc_r;
    t_nxt         = t_r;
    oui_hi_nxt    = oui_hi_r;
    hash_nxt      = hash_r;
    out_valid_nxt = out_valid_r;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (q_pop) begin
          op_nxt    = q_cmd.op;
          step_nxt  = 2'd0;
          pass_nxt  = 1'b0;
          phase_nxt = 1'b0;
          case (q_cmd.op)
            pfh_pkg::CMD_SEED_CONST: begin
              h_nxt = pfh_pkg::MIX_C;
            end
            pfh_pkg::CMD_SEED_OUI: begin
              x_nxt      = pfh_pkg::xs32(pfh_pkg::replicate({48'd0, q_cmd.data[15:0]}, 4'd2));
              oui_hi_nxt = q_cmd.data[23:16];
              state_nxt  = S_MUL;
            end
            pfh_pkg::CMD_MIX: begin
              x_nxt     = pfh_pkg::xs32(q_cmd.data);
              state_nxt = S_MUL;
            end
            default: begin
              hash_nxt      = h_r;
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end
      S_MUL: begin
        step_nxt = step_r + 2'd1;
        case (step_r)
          2'd0: begin
            prod_nxt = mul_p;
          end
          2'd1: begin
            acc_nxt  = prod_r;
            prod_nxt = mul_p;
          end
          2'd2: begin
            acc_nxt  = mul_res;
            prod_nxt = mul_p;
          end
          default: begin
            // Last partial product is in: finish this multiply.
            if (!pass_r) begin
              x_nxt    = pfh_pkg::xs32(mul_res);
              pass_nxt = 1'b1;
            end else if ((op_r == pfh_pkg::CMD_SEED_OUI) && !phase_r) begin
              h_nxt     = mul_res;
              phase_nxt = 1'b1;
              pass_nxt  = 1'b0;
              x_nxt     = pfh_pkg::xs32(pfh_pkg::replicate({56'd0, oui_hi_r}, 4'd1));
            end else begin
              t_nxt     = mul_res;
              state_nxt = S_ADD1;
            end
          end
        endcase
      end
      S_ADD1: begin
        t_nxt     = t_r + pfh_pkg::COMB_G;
        state_nxt = S_ADD2;
      end
      S_ADD2: begin
        t_nxt     = t_r + {h_r[57:0], 6'd0};
        state_nxt = S_ADD3;
      end
      S_ADD3: begin
        h_nxt     = h_r ^ (t_r + {2'd0, h_r[63:2]});
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers and the running hash.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= '0;
      pass_r      <= 1'b0;
      phase_r     <= 1'b0;
      op_r        <= pfh_pkg::CMD_SEED_CONST;
      out_valid_r <= 1'b0;
      h_r         <= '0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      pass_r      <= pass_nxt;
      phase_r     <= phase_nxt;
      op_r        <= op_nxt;
      out_valid_r <= out_valid_nxt;
      h_r         <= h_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    x_r      <= x_nxt;
    prod_r   <= prod_nxt;
    acc_r    <= acc_nxt;
    t_r      <= t_nxt;
    oui_hi_r <= oui_hi_nxt;
    hash_r   <= hash_nxt;
  end

endmodule

// File: rtl/probe_fingerprint_hash.sv
// Top level of the probe fingerprint hash: front end, command queue and back end.
// The front end takes one request per cycle while its four-entry command queue has room;
// start, end and each completed chunk of tag bytes place one command in the queue, other
// requests place none. The back end handles a chunk in an issue step, two
// 64-bit multiplies on a single shared 32x32 multiplier and three combining adds. A
// start with the OUI seed runs four multiplies, two for each part of the OUI, before
// the combining adds; a start with the constant seed and an end take only the issue
// step, an end also waiting for the result register to be taken. Sustained throughput
// is therefore set by the multiplier loop; the back end takes a command only when idle.
// Configuration writes are taken in any cycle and must only be issued while idle.
module probe_fingerprint_hash (
  input  logic      clk,
  input  logic      rst_n,
  pfh_in_if.sink    in_ch,
  pfh_out_if.source out_ch,
  pfh_cfg_if.sink   cfg_ch
);

  logic          q_push;
  pfh_pkg::cmd_t q_push_cmd;
  logic          q_full;
  logic          q_pop;
  logic          q_valid;
  pfh_pkg::cmd_t q_pop_cmd;

  // Request classification and tag tracking.
  pfh_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .cfg_ch (cfg_ch),
    .q_full (q_full),
    .q_push (q_push),
    .q_cmd  (q_push_cmd)
  );

  // Decoupling queue.
  pfh_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_cmd  (q_push_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_cmd   (q_pop_cmd)
  );

  // Mixer, combiner and result register.
  pfh_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_cmd   (q_pop_cmd),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule

// File: rtl/pfh_checker.sv
// Port-level assertions of the probe fingerprint hash and their bind to the top level.
module pfh_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [63:0] out_hash
);

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result request dropped while stalled");

  // A stalled result keeps its value.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_hash))
    else $error("result changed while stalled");

  // Reset leaves an empty queue and no pending result.
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> in_ready && !out_valid)
    else $error("block not idle after reset");

  // The queue fills only through an accepted request.
  a_ready_fall: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(in_ready) |-> $past(in_valid && in_ready))
    else $error("input ready dropped without a request");

endmodule

bind probe_fingerprint_hash pfh_checker u_pfh_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_hash  (out_ch.hash_value)
);

// File: tb/tb_probe_fingerprint_hash.sv
// Self-checking testbench of the probe fingerprint hash with a built-in hash predictor.
module tb_probe_fingerprint_hash;

  localparam int SETTLE_CYCLES = 200;
  localparam int RUN_LIMIT     = 1000000;

  logic clk = 1'b0;
  logic rst_n;

  pfh_in_if  in_bus();
  pfh_out_if out_bus();
  pfh_cfg_if cfg_bus();

  probe_fingerprint_hash i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus),
    .cfg_ch (cfg_bus)
  );

  always #1 clk = ~clk;

  // Idle and stall rates in percent for the current phase.
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;

  // Predictor state, mirroring the block after reset.
  logic        seed_from_oui = 1'b0;
  logic [63:0] fp_hash       = '0;
  logic [63:0] chunk_bytes   = '0;
  int unsigned chunk_count   = 0;
  int unsigned chunk_len     = 0;
  int unsigned tag_pos       = 0;
  int unsigned tag_len       = 0;

  logic [63:0] expected_hashes[$];
  int unsigned requests_taken = 0;
  int unsigned ends_taken     = 0;
  int unsigned error_count    = 0;

  // Hash arithmetic, all modulo 2^64.
  function automatic logic [63:0] fold_half(input logic [63:0] v);
    return v ^ (v >> 32);
  endfunction

  function automatic logic [63:0] scramble(input logic [63:0] x);
    logic [63:0] t;
    t = pfh_pkg::MIX_P * fold_half(x);
    return pfh_pkg::MIX_C * fold_half(t);
  endfunction

  function automatic logic [63:0] widen_chunk(input logic [63:0] v, input int unsigned nbytes);
    logic [63:0] r;
    int unsigned w;
    r = v;
    w = nbytes * 8;
    while (w < 64) begin
      r = r | (r << w);
      w = w * 2;
    end
    return r;
  endfunction

  function automatic logic [63:0] fold_into(input logic [63:0] h, input logic [63:0] v);
    return h ^ (v + pfh_pkg::COMB_G + (h << 6) + (h >> 2));
  endfunction

  function automatic int unsigned next_chunk_len(input int unsigned pos, input int unsigned len);
    if (pos + 8 < len) return 8;
    if (pos + 4 < len) return 4;
    if (pos + 2 < len) return 2;
    return 1;
  endfunction

  task automatic drop_tag();
    chunk_bytes = '0;
    chunk_count = 0;
    chunk_len   = 0;
    tag_pos     = 0;
    tag_len     = 0;
  endtask

  // Advance the predicted fingerprint by one accepted request.
  task automatic advance_fingerprint(input logic [1:0] op, input logic [23:0] oui,
                                     input logic [7:0] len, input logic [7:0] data_b);
    case (op)
      pfh_pkg::OP_START: begin
        if (seed_from_oui) begin
          fp_hash = fold_into(scramble(widen_chunk({48'd0, oui[15:0]}, 2)),
                              scramble(widen_chunk({56'd0, oui[23:16]}, 1)));
        end else begin
          fp_hash = pfh_pkg::MIX_C;
        end
        drop_tag();
        requests_taken++;
      end
      pfh_pkg::OP_BEGIN: begin
        drop_tag();
        tag_len   = len;
        chunk_len = next_chunk_len(0, len);
        requests_taken++;
      end
      pfh_pkg::OP_BYTE: begin
        // A byte outside an open tag leaves the state untouched.
        if (tag_pos < tag_len) begin
          chunk_bytes = chunk_bytes | ({56'd0, data_b} << (8 * chunk_count));
          chunk_count++;
          tag_pos++;
          if (chunk_count >= chunk_len) begin
            fp_hash     = fold_into(fp_hash, scramble(widen_chunk(chunk_bytes, chunk_len)));
            chunk_bytes = '0;
            chunk_count = 0;
            chunk_len   = next_chunk_len(tag_pos, tag_len);
          end
          requests_taken++;
        end
      end
      default: begin
        expected_hashes.push_back(fp_hash);
        drop_tag();
        requests_taken++;
        ends_taken++;
      end
    endcase
  endtask

  task automatic report_mismatch(input string what);
    $display("ERROR at %0t: %s", $time, what);
    error_count++;
  endtask

  // Send one request; the field that the opcode reads gets arg, the others random values.
  task automatic send_request(input logic [1:0] op, input logic [23:0] arg);
    logic [23:0] oui_f;
    logic [7:0]  len_f;
    logic [7:0]  byte_f;
    oui_f  = (op == pfh_pkg::OP_START) ? arg : 24'($urandom);
    len_f  = (op == pfh_pkg::OP_BEGIN) ? arg[7:0] : 8'($urandom);
    byte_f = (op == pfh_pkg::OP_BYTE) ? arg[7:0] : 8'($urandom);
    while ($urandom_range(99) < send_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(posedge clk);
    end
    in_bus.valid      <= 1'b1;
    in_bus.opcode     <= op;
    in_bus.oui        <= oui_f;
    in_bus.ie_length  <= len_f;
    in_bus.data_byte  <= byte_f;
    // Ready comes from registers, so its value at the falling edge holds at the next rise.
    @(negedge clk);
    while (!in_bus.ready) @(negedge clk);
    @(posedge clk);
    advance_fingerprint(op, oui_f, len_f, byte_f);
  endtask

  task automatic send_tag(input int unsigned len, input int unsigned nbytes);
    send_request(pfh_pkg::OP_BEGIN, 24'(len));
    repeat (nbytes) send_request(pfh_pkg::OP_BYTE, 24'($urandom_range(255)));
  endtask

  // Stop sending and let every pending hash and any queued chunk work finish.
  task automatic settle_block();
    in_bus.valid <= 1'b0;
    while (expected_hashes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_use_oui(input logic mode);
    settle_block();
    cfg_bus.valid   <= 1'b1;
    cfg_bus.use_oui <= mode;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    cfg_bus.valid <= 1'b0;
    seed_from_oui = mode;
  endtask

  // Result checker: a hash offered and taken at the next rising edge must match the
  // oldest pending one. Valid, ready and the hash only change at rising edges.
  always @(negedge clk) begin : check_hashes
    logic [63:0] want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (expected_hashes.size() == 0) begin
        report_mismatch($sformatf("unexpected hash %h", out_bus.hash_value));
      end else begin
        want = expected_hashes.pop_front();
        if (out_bus.hash_value !== want) begin
          report_mismatch($sformatf("hash_value %h, predicted %h", out_bus.hash_value, want));
        end
      end
    end
  end

  // Receiver backpressure.
  always @(posedge clk) begin
    out_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // End with no start after reset yields zero; a stray byte before it is ignored.
  task automatic test_no_start();
    send_request(pfh_pkg::OP_BYTE, 24'hFF);
    send_request(pfh_pkg::OP_END, '0);
  endtask

  // Constant seed with an empty tag and a tag cut into a two-byte and a one-byte chunk.
  task automatic test_constant_seed();
    write_use_oui(1'b0);
    send_request(pfh_pkg::OP_START, 24'h000000);
    send_tag(0, 0);
    send_request(pfh_pkg::OP_BEGIN, 24'd3);
    send_request(pfh_pkg::OP_BYTE, 24'hFF);
    send_request(pfh_pkg::OP_BYTE, 24'h00);
    send_request(pfh_pkg::OP_BYTE, 24'hA5);
    send_request(pfh_pkg::OP_END, '0);
  endtask

  // OUI seed at both extremes of the OUI.
  task automatic test_oui_seed();
    write_use_oui(1'b1);
    send_request(pfh_pkg::OP_START, 24'hFFFFFF);
    send_request(pfh_pkg::OP_BEGIN, 24'd1);
    send_request(pfh_pkg::OP_BYTE, 24'h00);
    send_request(pfh_pkg::OP_END, '0);
    send_request(pfh_pkg::OP_START, 24'h000000);
  endtask

  // Interrupted tag, stray byte, start mid-record, end with open tag, back-to-back ends.
  task automatic test_special_cases();
    send_tag(12, 3);
    send_request(pfh_pkg::OP_BEGIN, 24'd1);
    send_request(pfh_pkg::OP_BYTE, 24'hFF);
    send_request(pfh_pkg::OP_BYTE, 24'h00);
    send_request(pfh_pkg::OP_START, 24'($urandom));
    send_tag(9, 2);
    send_request(pfh_pkg::OP_END, '0);
    send_request(pfh_pkg::OP_END, '0);
  endtask

  // One random record: mostly well-formed tags, with cut tags, stray bytes and noise.
  task automatic random_record(input int unsigned long_len);
    int unsigned tags;
    int unsigned len;
    int unsigned nbytes;
    int unsigned roll;
    if ($urandom_range(99) < 90) send_request(pfh_pkg::OP_START, 24'($urandom));
    if (long_len != 0) send_tag(long_len, long_len);
    tags = $urandom_range(3);
    for (int t = 0; t < tags; t++) begin
      roll = $urandom_range(99);
      if (roll < 80) len = $urandom_range(8);
      else if (roll < 97) len = $urandom_range(40, 9);
      else len = $urandom_range(255, 41);
      roll = $urandom_range(99);
      if (roll < 80) nbytes = len;
      else if (roll < 90) nbytes = (len == 0) ? 0 : $urandom_range(len - 1);
      else nbytes = len + $urandom_range(3, 1);
      if ($urandom_range(99) < 4) send_request(pfh_pkg::OP_START, 24'($urandom));
      send_tag(len, nbytes);
    end
    if ($urandom_range(99) < 6) begin
      repeat ($urandom_range(6, 1)) send_request(2'($urandom), 24'($urandom));
    end
    send_request(pfh_pkg::OP_END, '0);
  endtask

  task automatic test_random(input int unsigned idle_pct, input int unsigned stall_pct,
                             input logic mode, input int unsigned long_len);
    int unsigned base_reqs;
    int unsigned base_ends;
    int unsigned first_len;
    write_use_oui(mode);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    base_reqs = requests_taken;
    base_ends = ends_taken;
    first_len = long_len;
    while (requests_taken - base_reqs < 90 || ends_taken - base_ends < 3) begin
      random_record(first_len);
      first_len = 0;
    end
  endtask

  initial begin
    rst_n              <= 1'b0;
    in_bus.valid       <= 1'b0;
    in_bus.opcode      <= pfh_pkg::OP_START;
    in_bus.oui         <= '0;
    in_bus.ie_length   <= '0;
    in_bus.data_byte   <= '0;
    cfg_bus.valid      <= 1'b0;
    cfg_bus.use_oui    <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    test_no_start();
    test_constant_seed();
    test_oui_seed();
    test_special_cases();
    test_random(0, 0, 1'b1, 255);
    test_random(58, 0, 1'b0, 0);
    test_random(0, 58, 1'b1, 0);
    test_random(18, 18, 1'b0, 0);

    settle_block();
    if (error_count == 0 && expected_hashes.size() == 0) begin
      $display("probe_fingerprint_hash: match");
    end else begin
      $display("probe_fingerprint_hash: mismatch");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #(RUN_LIMIT);
    $display("probe_fingerprint_hash: mismatch");
    $finish;
  end

endmodule

// File: sim.f
rtl/pfh_pkg.sv
rtl/pfh_if.sv
rtl/pfh_front.sv
rtl/pfh_queue.sv
rtl/pfh_back.sv
rtl/probe_fingerprint_hash.sv
rtl/pfh_checker.sv
tb/tb_probe_fingerprint_hash.sv
